FILE: rtl/ps2ct_pkg.sv
// Shared constants, register indexes and clamp function for the PS/2 cursor tracker.
package ps2ct_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FINE_W   = 16;
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned SHIFT_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_W    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_SHIFT = 2'd2;

  localparam logic [BYTE_W-1:0]  GRID_COLUMNS_RST      = 8'd80;
  localparam logic [BYTE_W-1:0]  GRID_ROWS_RST         = 8'd25;
  localparam logic [SHIFT_W-1:0] SENSITIVITY_SHIFT_RST = 3'd2;

  // Header bit positions
  localparam int unsigned HDR_LEFT   = 0;
  localparam int unsigned HDR_RIGHT  = 1;
  localparam int unsigned HDR_MIDDLE = 2;
  localparam int unsigned HDR_XSIGN  = 4;
  localparam int unsigned HDR_YSIGN  = 5;

  typedef struct packed {
    logic       button_left;
    logic       button_right;
    logic       button_middle;
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
  } result_t;

  // Floor at zero, then pull the cell back to limit-1 when it runs past the grid.
  // A zero limit acts as one.
  function automatic logic [FINE_W-1:0] clamp_axis(input logic signed [SUM_W-1:0] pos,
                                                   input logic [BYTE_W-1:0] limit,
                                                   input logic [SHIFT_W-1:0] shift);
    logic [BYTE_W-1:0]  top;
    logic [SUM_W-2:0]   mag;
    logic [SUM_W-2:0]   cell_idx;
    logic [FINE_W-1:0]  top_fine;
    top      = (limit == '0) ? '0 : limit - 8'd1;
    mag      = pos[SUM_W-1] ? '0 : pos[SUM_W-2:0];
    cell_idx = mag >> shift;
    top_fine = {8'd0, top} << shift;
    if (cell_idx > {9'd0, top}) begin
      return top_fine;
    end else begin
      return mag[FINE_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/ps2_mouse_packet_cursor_tracker.sv
// Top level: PS/2 mouse packet decoder and clamped cursor position tracker.
//
// Usage:
//   s_* carries one controller byte per word: s_tdata is the byte, s_tuser is
//   the auxiliary-device flag. Bytes without the flag are dropped. Flagged
//   bytes form 3-byte packets (header, X, Y) with no alignment check.
//   m_* carries one word per packet with nonzero X or Y: column and row cell
//   plus the three button bits. Packets with zero X and Y give no word.
//   cfg_* writes grid_columns (0), grid_rows (1) and sensitivity_shift (2);
//   write only while the block is idle. cfg_ready is always high.
// Path: a byte is held in the input register, then the update and result
//   land in the output register; m_tvalid rises at the edge that consumes
//   the last byte of a moving packet from the input register.
// Throughput: one byte per cycle while no word waits on a low m_tready; the
//   add-and-clamp path lies between the input and output registers.
// Reset: position, packet counter and the valid flags of both registers
//   clear; configuration returns to 80 columns, 25 rows, shift 2.
// Stall: while m_tready is low with a word waiting, the input register holds
//   and s_tready drops once it is full.
module ps2_mouse_packet_cursor_tracker
  import ps2ct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,    // [7:0] data_byte
  input  logic                 s_tuser,    // [0] from_aux
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,    // [7:0] cursor_col, [15:8] cursor_row,
                                           // [16] button_middle, [17] button_right,
                                           // [18] button_left, [23:19] zero
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [BYTE_W-1:0]  grid_columns;
  logic [BYTE_W-1:0]  grid_rows;
  logic [SHIFT_W-1:0] sensitivity_shift;

  logic               in_valid;
  logic [BYTE_W-1:0]  in_byte;
  logic               in_aux;

  logic [BYTE_W-1:0]  hdr;
  logic [BYTE_W-1:0]  bx;
  logic [1:0]         byte_index;
  logic [FINE_W-1:0]  fine_x;
  logic [FINE_W-1:0]  fine_y;

  logic               out_valid;
  result_t            out_word;

  logic                     advance;
  logic                     consume;
  logic                     take_byte;
  logic                     last_byte;
  logic                     moving;
  logic signed [8:0]        dx;
  logic signed [8:0]        dy;
  logic signed [SUM_W-1:0]  pos_x;
  logic signed [SUM_W-1:0]  pos_y;
  logic [FINE_W-1:0]        fine_x_next;
  logic [FINE_W-1:0]        fine_y_next;
  result_t                  out_word_next;
  logic [FINE_W-1:0]        cell_x;
  logic [FINE_W-1:0]        cell_y;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || m_tready;
  assign consume   = in_valid && advance;
  assign s_tready  = !in_valid || advance;
  assign take_byte = consume && in_aux;
  assign last_byte = byte_index[1];
  assign moving    = (bx != '0) || (in_byte != '0);

  always_comb begin
    dx = signed'({hdr[HDR_XSIGN], bx});
    dy = signed'({hdr[HDR_YSIGN], in_byte});
    pos_x = signed'({2'b00, fine_x}) + {{(SUM_W-9){dx[8]}}, dx};
    pos_y = signed'({2'b00, fine_y}) - {{(SUM_W-9){dy[8]}}, dy};
    fine_x_next = clamp_axis(pos_x, grid_columns, sensitivity_shift);
    fine_y_next = clamp_axis(pos_y, grid_rows, sensitivity_shift);
    cell_x = fine_x_next >> sensitivity_shift;
    cell_y = fine_y_next >> sensitivity_shift;
    out_word_next.cursor_col    = cell_x[7:0];
    out_word_next.cursor_row    = cell_y[7:0];
    out_word_next.button_middle = hdr[HDR_MIDDLE];
    out_word_next.button_right  = hdr[HDR_RIGHT];
    out_word_next.button_left   = hdr[HDR_LEFT];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns      <= GRID_COLUMNS_RST;
      grid_rows         <= GRID_ROWS_RST;
      sensitivity_shift <= SENSITIVITY_SHIFT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_COLUMNS:      grid_columns      <= cfg_data;
        REG_GRID_ROWS:         grid_rows         <= cfg_data;
        REG_SENSITIVITY_SHIFT: sensitivity_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_aux  <= s_tuser;
    end
  end

  // Packet assembly and position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 2'd0;
      hdr        <= '0;
      bx         <= '0;
      fine_x     <= '0;
      fine_y     <= '0;
    end else if (take_byte) begin
      if (last_byte) begin
        byte_index <= 2'd0;
        if (moving) begin
          fine_x <= fine_x_next;
          fine_y <= fine_y_next;
        end
      end else begin
        byte_index <= byte_index + 2'd1;
        if (byte_index[0]) begin
          bx <= in_byte;
        end else begin
          hdr <= in_byte;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= take_byte && last_byte && moving;
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte && last_byte && moving) begin
      out_word <= out_word_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_word};

  // Checks
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index != 2'd3)
    else $error("packet byte counter reached three");

  a_fine_x_msb: assert property (@(posedge clk) disable iff (rst)
    !fine_x[FINE_W-1] && !fine_y[FINE_W-1])
    else $error("fine position beyond largest clamp value");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_aux && byte_index == 2'd2))
    else $error("result word without a completed packet");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without a waiting result");

endmodule

FILE: bench/tb_ps2_mouse_packet_cursor_tracker.sv
// Self-checking bench for the PS/2 mouse packet cursor tracker: directed and random byte streams.
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_cursor_tracker;
  import ps2ct_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned PHASE_BYTES = 100;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       mid;
    logic       right;
    logic       left;
  } cursor_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  ps2_mouse_packet_cursor_tracker DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Tracker copy: registers, packet assembly and fine position
  logic [7:0]  grid_cols;
  logic [7:0]  grid_rows;
  logic [2:0]  cell_shift;
  logic [7:0]  pkt_hdr;
  logic [7:0]  pkt_x;
  int unsigned pkt_count;
  logic [15:0] fine_x_pos;
  logic [15:0] fine_y_pos;

  cursor_report_t pending_reports[$];
  int unsigned report_errors = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [15:0] clamp_fine(input int pos, input logic [7:0] lim,
                                             input logic [2:0] sh);
    int top;
    top = (lim == 8'd0) ? 0 : int'(lim) - 1;
    if (pos < 0) pos = 0;
    if ((pos >> sh) > top) pos = top << sh;
    return pos[15:0];
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic aux);
    int dx;
    int dy;
    cursor_report_t rep;
    if (!aux) return;
    if (pkt_count < 2) begin
      if (pkt_count == 0) pkt_hdr = b;
      else pkt_x = b;
      pkt_count++;
      return;
    end
    pkt_count = 0;
    // Button-only packet: no move, no word
    if (pkt_x == 8'd0 && b == 8'd0) return;
    dx = int'(pkt_x) - (pkt_hdr[HDR_XSIGN] ? 256 : 0);
    dy = int'(b) - (pkt_hdr[HDR_YSIGN] ? 256 : 0);
    fine_x_pos = clamp_fine(int'(fine_x_pos) + dx, grid_cols, cell_shift);
    fine_y_pos = clamp_fine(int'(fine_y_pos) - dy, grid_rows, cell_shift);
    rep.col   = 8'(fine_x_pos >> cell_shift);
    rep.row   = 8'(fine_y_pos >> cell_shift);
    rep.mid   = pkt_hdr[HDR_MIDDLE];
    rep.right = pkt_hdr[HDR_RIGHT];
    rep.left  = pkt_hdr[HDR_LEFT];
    pending_reports.push_back(rep);
  endfunction

  function automatic void reset_tracker();
    grid_cols  = GRID_COLUMNS_RST;
    grid_rows  = GRID_ROWS_RST;
    cell_shift = SENSITIVITY_SHIFT_RST;
    pkt_hdr    = 8'd0;
    pkt_x      = 8'd0;
    pkt_count  = 0;
    fine_x_pos = 16'd0;
    fine_y_pos = 16'd0;
  endfunction

  // Sink-side stall pattern
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Result checker: the handshake seen at negedge completes at the next rising edge
  always @(negedge clk) begin
    cursor_report_t got;
    cursor_report_t exp_rep;
    if (!rst && m_tvalid && m_tready) begin
      got.col   = m_tdata[7:0];
      got.row   = m_tdata[15:8];
      got.mid   = m_tdata[16];
      got.right = m_tdata[17];
      got.left  = m_tdata[18];
      if (pending_reports.size() == 0) begin
        report_errors++;
        if (report_errors <= 10)
          $display("unexpected cursor word: col %0d row %0d m%0b r%0b l%0b",
                   got.col, got.row, got.mid, got.right, got.left);
      end else begin
        exp_rep = pending_reports.pop_front();
        if (got !== exp_rep) begin
          report_errors++;
          if (report_errors <= 10)
            $display("cursor word mismatch: expected col %0d row %0d m%0b r%0b l%0b, %s",
                     exp_rep.col, exp_rep.row, exp_rep.mid, exp_rep.right, exp_rep.left,
                     $sformatf("got col %0d row %0d m%0b r%0b l%0b",
                               got.col, got.row, got.mid, got.right, got.left));
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on any channel
  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ps2_mouse_packet_cursor_tracker test failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic aux);
    logic took;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= aux;
    do begin
      @(negedge clk);
      took = s_tready;
      if (took) track_byte(b, aux);
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] x, input logic [7:0] y);
    send_byte(hdr, 1'b1);
    send_byte(x, 1'b1);
    send_byte(y, 1'b1);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    case (idx)
      REG_GRID_COLUMNS:      grid_cols = val;
      REG_GRID_ROWS:         grid_rows = val;
      REG_SENSITIVITY_SHIFT: cell_shift = val[2:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [7:0] cols, input logic [7:0] rows,
                          input logic [7:0] sh);
    write_reg(REG_GRID_COLUMNS, cols);
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_SENSITIVITY_SHIFT, sh);
  endtask

  task automatic test_reset_config();
    send_packet(8'h00, 8'h05, 8'h03);
    send_packet(8'h30, 8'hFE, 8'hFF);
  endtask

  task automatic test_directed();
    // All buttons, largest positive X, then run past the right edge
    send_packet(8'h07, 8'hFF, 8'h00);
    send_packet(8'h00, 8'hFF, 8'h00);
    // Non-aux bytes inside a packet change nothing
    send_byte(8'h20, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b1);
    // Zero X byte with sign set moves by -256
    send_packet(8'h12, 8'h00, 8'h01);
    // Overflow and spare header bits are ignored
    send_packet(8'hDD, 8'h01, 8'h01);
    // Button change only: no word
    send_packet(8'h07, 8'h00, 8'h00);
    // Stray byte shifts packet framing, two more bytes realign
    send_byte(8'h00, 1'b1);
    send_packet(8'h01, 8'h40, 8'h10);
    send_byte(8'h00, 1'b0);
    send_byte(8'h08, 1'b1);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_config_extremes();
    settle();
    set_grid(8'd255, 8'd255, 8'd7);
    repeat (3) send_packet(8'h20, 8'hFF, 8'h01);
    settle();
    set_grid(8'd1, 8'd1, 8'd0);
    send_packet(8'h00, 8'h7F, 8'hF0);
    send_packet(8'h30, 8'h10, 8'h10);
    settle();
    // Zero limits act as one; the unused index is ignored
    set_grid(8'd0, 8'd0, 8'hFD);
    write_reg(REG_UNUSED, 8'hFF);
    send_packet(8'h03, 8'hC0, 8'h22);
    send_packet(8'h34, 8'h80, 8'h80);
    settle();
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned pick;
    logic paused;
    logic [7:0] hx;
    logic [7:0] hy;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 24; snk_stall_pct = 24; end
      endcase
      settle();
      case (phase)
        0: set_grid(8'd255, 8'd255, 8'd7);
        1: set_grid(8'd1, 8'd1, 8'd0);
        default: set_grid(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
      endcase
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_BYTES) begin
        if (!paused && sent >= PHASE_BYTES / 2) begin
          settle();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          hx = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
          hy = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
          send_packet(8'($urandom_range(0, 255)), hx, hy);
          sent += 3;
        end else if (pick < 92) begin
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'b1);
          sent++;
        end
      end
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
  endtask

  initial begin
    reset_tracker();
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_directed();
    test_config_extremes();
    test_random();
    settle();
    report_errors += pending_reports.size();
    if (report_errors == 0) begin
      $display("ps2_mouse_packet_cursor_tracker test passed");
    end else begin
      $display("ps2_mouse_packet_cursor_tracker test failed");
    end
    $finish;
  end

endmodule
